@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OPLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define OPLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OPLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OPLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/opls_pkg.sv @@
// Shared constants, types and the square-root step of the lag search core.
// No dependencies.
package opls_pkg;
    localparam int MAX_POINTS = 128;
    localparam int COORD_BITS = 16;
    localparam int MIN_POINTS = 4;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int LAG_W      = ADDR_W - 1;
    localparam int WORD_W     = 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int ROOT_W     = MAG_W + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SUM_W      = ROOT_W + ADDR_W;
    localparam int PROD_W     = SUM_W + CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             dropped;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic             last;
        logic [LAG_W-1:0] lag;
    } t_tag;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    function automatic t_sq sqrt_step(input logic [REM_W-1:0] rem,
                                      input logic [ROOT_W-1:0] root,
                                      input logic [1:0] pair);
        t_sq              res;
        logic [REM_W-1:0] rt;
        logic [REM_W-1:0] trial;
        rt    = {rem[REM_W-3:0], pair};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
        if (rt >= trial) begin
            res.rem  = rt - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rt;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction
endpackage

@@ rtl/core/orbit_period_lag_search_core.sv @@
// Top level of the orbit period lag search core.
// Depends on opls_pkg, opls_ram, opls_front, opls_back.
//
// Usage: points (signed Q8.8 x and y) are accepted one word per cycle while
// start is high and busy is low. The word with i_last_point set closes the
// sequence; busy then stays high until the cycle that carries the final result.
// At most 128 points are kept; later ones are dropped and o_overflow is set
// on every result of that sequence.
// Results appear for one cycle each with o_valid high: one edge per cycle for
// i = 0 .. N/2-1, the final one with o_last_edge. With fewer than four points
// a single word with o_edge_valid low is given.
// The search runs one point-pair distance per cycle through one 17-stage root
// pipeline, one lag after another; once the pipeline drains, the results go out.
// Reset (synchronous, active low) empties the sequence and the job queue;
// the point store needs no clearing. The receiver cannot stall results.
module orbit_period_lag_search_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [opls_pkg::COORD_BITS-1:0] i_point_x,
    input  logic [opls_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                            i_last_point,
    output logic                            o_valid,
    output logic [opls_pkg::ADDR_W-1:0]     o_edge_from,
    output logic [opls_pkg::ADDR_W-1:0]     o_edge_to,
    output logic [opls_pkg::LAG_W-1:0]      o_chosen_lag,
    output logic                            o_edge_valid,
    output logic                            o_overflow,
    output logic                            o_last_edge
);
    import opls_pkg::*;

    t_wr               wr;
    t_job              job;
    logic              job_valid, pop, back_active;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [WORD_W-1:0] rdata_a, rdata_b;

    opls_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_back_active(back_active),
        .i_pop        (pop),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .o_wr         (wr)
    );

    opls_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (wr.en),
        .i_waddr(wr.addr),
        .i_wdata(wr.data),
        .i_raddr(raddr_a),
        .o_rdata(rdata_a)
    );

    opls_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (wr.en),
        .i_waddr(wr.addr),
        .i_wdata(wr.data),
        .i_raddr(raddr_b),
        .o_rdata(rdata_b)
    );

    opls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_active    (back_active),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_valid     (o_valid),
        .o_edge_from (o_edge_from),
        .o_edge_to   (o_edge_to),
        .o_chosen_lag(o_chosen_lag),
        .o_edge_valid(o_edge_valid),
        .o_overflow  (o_overflow),
        .o_last_edge (o_last_edge)
    );
endmodule

@@ rtl/core/opls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/opls_front.sv @@
// Front end: takes point words, writes the point store, queues a closed sequence.
// Depends on opls_pkg.
module opls_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [opls_pkg::COORD_BITS-1:0] i_point_x,
    input  logic [opls_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    input  logic                         i_back_active,
    input  logic                         i_pop,
    output logic                         o_job_valid,
    output opls_pkg::t_job               o_job,
    output opls_pkg::t_wr                o_wr
);
    import opls_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic             r_job_valid;
    t_job             r_job;
    logic             accept;
    logic             room;

    assign busy   = r_job_valid || i_back_active;
    assign accept = start && !busy;
    assign room   = r_count < CNT_W'(MAX_POINTS);

    assign o_wr.en   = accept && room;
    assign o_wr.addr = r_count[ADDR_W-1:0];
    assign o_wr.data = {i_point_x, i_point_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_pop) begin
                r_job_valid <= 1'b0;
            end
            if (accept) begin
                if (i_last_point) begin
                    r_job_valid   <= 1'b1;
                    r_job.n       <= room ? r_count + CNT_W'(1) : r_count;
                    r_job.dropped <= r_dropped || !room;
                    r_count       <= '0;
                    r_dropped     <= 1'b0;
                end else if (room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
endmodule

@@ rtl/core/opls_dist.sv @@
// Distance pipeline: |a-b| per axis, squares, sum, then one root bit per stage.
// Depends on opls_pkg.
module opls_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  opls_pkg::t_tag              i_tag,
    input  logic [opls_pkg::WORD_W-1:0] i_a,
    input  logic [opls_pkg::WORD_W-1:0] i_b,
    output logic                        o_vld,
    output opls_pkg::t_tag              o_tag,
    output logic [opls_pkg::ROOT_W-1:0] o_dist
);
    import opls_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;

    logic              r_va, r_vb, r_vc;
    t_tag              r_ta, r_tb, r_tc;
    logic [MAG_W-1:0]  r_mx, r_my;
    logic [2*MAG_W-1:0] r_sqx, r_sqy;
    logic [RAD_W-1:0]  r_sum;

    logic              r_vs   [ROOT_W];
    t_tag              r_ts   [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  n_rad  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    assign dx = $signed({i_a[WORD_W-1], i_a[WORD_W-1:COORD_BITS]})
              - $signed({i_b[WORD_W-1], i_b[WORD_W-1:COORD_BITS]});
    assign dy = $signed({i_a[COORD_BITS-1], i_a[COORD_BITS-1:0]})
              - $signed({i_b[COORD_BITS-1], i_b[COORD_BITS-1:0]});
    assign ax = dx < 0 ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ay = dy < 0 ? DIFF_W'(-dy) : DIFF_W'(dy);

    always_comb begin
        t_sq              st;
        logic [RAD_W-1:0]  src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        for (int s = 0; s < ROOT_W; s++) begin
            src_rad  = (s == 0) ? r_sum : r_rad[s == 0 ? 0 : s-1];
            src_rem  = (s == 0) ? '0 : r_rem[s == 0 ? 0 : s-1];
            src_root = (s == 0) ? '0 : r_root[s == 0 ? 0 : s-1];
            st        = sqrt_step(src_rem, src_root, src_rad[RAD_W-1 -: 2]);
            n_rem[s]  = st.rem;
            n_root[s] = st.root;
            n_rad[s]  = src_rad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            for (int s = 0; s < ROOT_W; s++) begin
                r_vs[s] <= 1'b0;
            end
        end else begin
            r_va <= i_vld;
            r_vb <= r_va;
            r_vc <= r_vb;
            for (int s = 0; s < ROOT_W; s++) begin
                r_vs[s] <= (s == 0) ? r_vc : r_vs[s == 0 ? 0 : s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta  <= i_tag;
        r_mx  <= ax[MAG_W-1:0];
        r_my  <= ay[MAG_W-1:0];
        r_tb  <= r_ta;
        r_sqx <= r_mx * r_mx;
        r_sqy <= r_my * r_my;
        r_tc  <= r_tb;
        r_sum <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
        for (int s = 0; s < ROOT_W; s++) begin
            r_ts[s]   <= (s == 0) ? r_tc : r_ts[s == 0 ? 0 : s-1];
            r_rad[s]  <= n_rad[s];
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
        end
    end

    assign o_vld  = r_vs[ROOT_W-1];
    assign o_tag  = r_ts[ROOT_W-1];
    assign o_dist = r_root[ROOT_W-1];
endmodule

@@ rtl/core/opls_back.sv @@
// Back end: sweeps lags over the point store, sums distances, picks the best lag by cross-multiplied
// means and emits the edge words. Depends on opls_pkg, opls_dist and assert_macros.svh.
`include "assert_macros.svh"
module opls_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  opls_pkg::t_job              i_job,
    output logic                        o_pop,
    output logic                        o_active,
    output logic [opls_pkg::ADDR_W-1:0] o_raddr_a,
    output logic [opls_pkg::ADDR_W-1:0] o_raddr_b,
    input  logic [opls_pkg::WORD_W-1:0] i_rdata_a,
    input  logic [opls_pkg::WORD_W-1:0] i_rdata_b,
    output logic                        o_valid,
    output logic [opls_pkg::ADDR_W-1:0] o_edge_from,
    output logic [opls_pkg::ADDR_W-1:0] o_edge_to,
    output logic [opls_pkg::LAG_W-1:0]  o_chosen_lag,
    output logic                        o_edge_valid,
    output logic                        o_overflow,
    output logic                        o_last_edge
);
    import opls_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_EMIT, S_SHORT} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_half;
    logic              r_dropped;
    logic [ADDR_W-1:0] r_i;
    logic [LAG_W-1:0]  r_lag;
    logic [ADDR_W-1:0] r_e;
    logic              r_iss_vld;
    t_tag              r_iss_tag;
    logic              r_valid;
    logic [ADDR_W-1:0] r_from, r_to;
    logic [LAG_W-1:0]  r_lag_out;
    logic              r_edge_valid, r_ovf, r_last;

    logic              dist_vld;
    t_tag              dist_tag;
    logic [ROOT_W-1:0] dist_val;

    logic [SUM_W-1:0]  r_acc, r_cand_sum, r_best_sum;
    logic [CNT_W-1:0]  r_cand_cnt, r_best_cnt;
    logic [LAG_W-1:0]  r_cand_lag, r_best_lag;
    logic [PROD_W-1:0] r_prod_a, r_prod_b;
    logic              r_go1, r_go2, r_search_done;

    logic pop, iss_last, lag_end, emit_last;

    assign pop       = (r_state == S_IDLE) && i_job_valid;
    assign iss_last  = CNT_W'(r_i) + CNT_W'(r_lag) + CNT_W'(1) == r_n;
    assign lag_end   = CNT_W'(r_lag) == r_half - CNT_W'(1);
    assign emit_last = CNT_W'(r_e) + CNT_W'(1) == r_half;

    assign o_pop     = pop;
    assign o_active  = r_state != S_IDLE;
    assign o_raddr_a = r_i;
    assign o_raddr_b = r_i + ADDR_W'(r_lag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_iss_vld <= 1'b0;
            r_valid   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_n       <= i_job.n;
                        r_half    <= i_job.n >> 1;
                        r_dropped <= i_job.dropped;
                        r_i       <= '0;
                        r_lag     <= LAG_W'(1);
                        r_state   <= (i_job.n < CNT_W'(MIN_POINTS)) ? S_SHORT : S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_iss_vld      <= 1'b1;
                    r_iss_tag.last <= iss_last;
                    r_iss_tag.lag  <= r_lag;
                    if (iss_last) begin
                        r_i <= '0;
                        if (lag_end) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_lag <= r_lag + LAG_W'(1);
                        end
                    end else begin
                        r_i <= r_i + ADDR_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_search_done) begin
                        r_e     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid      <= 1'b1;
                    r_from       <= r_e;
                    r_to         <= r_e + ADDR_W'(r_best_lag);
                    r_lag_out    <= r_best_lag;
                    r_edge_valid <= 1'b1;
                    r_ovf        <= r_dropped;
                    r_last       <= emit_last;
                    if (emit_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_e <= r_e + ADDR_W'(1);
                    end
                end
                S_SHORT: begin
                    r_valid      <= 1'b1;
                    r_from       <= '0;
                    r_to         <= '0;
                    r_lag_out    <= '0;
                    r_edge_valid <= 1'b0;
                    r_ovf        <= r_dropped;
                    r_last       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    opls_dist u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_iss_vld),
        .i_tag  (r_iss_tag),
        .i_a    (i_rdata_a),
        .i_b    (i_rdata_b),
        .o_vld  (dist_vld),
        .o_tag  (dist_tag),
        .o_dist (dist_val)
    );

    // per-lag sum, then a*cnt_b <= b*cnt_a over two registered steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go1         <= 1'b0;
            r_go2         <= 1'b0;
            r_search_done <= 1'b0;
            r_acc         <= '0;
            r_best_lag    <= '0;
        end else begin
            r_go1         <= 1'b0;
            r_go2         <= r_go1;
            r_search_done <= 1'b0;
            if (pop) begin
                r_acc      <= '0;
                r_best_lag <= '0;
            end
            if (dist_vld) begin
                if (dist_tag.last) begin
                    r_acc      <= '0;
                    r_cand_sum <= r_acc + SUM_W'(dist_val);
                    r_cand_lag <= dist_tag.lag;
                    r_cand_cnt <= r_n - CNT_W'(dist_tag.lag);
                    r_go1      <= 1'b1;
                end else begin
                    r_acc <= r_acc + SUM_W'(dist_val);
                end
            end
            if (r_go1) begin
                r_prod_a <= PROD_W'(r_cand_sum) * PROD_W'(r_best_cnt);
                r_prod_b <= PROD_W'(r_best_sum) * PROD_W'(r_cand_cnt);
            end
            if (r_go2) begin
                if (r_best_lag == '0 || r_prod_a <= r_prod_b) begin
                    r_best_lag <= r_cand_lag;
                    r_best_sum <= r_cand_sum;
                    r_best_cnt <= r_cand_cnt;
                end
                if (CNT_W'(r_cand_lag) == r_half - CNT_W'(1)) begin
                    r_search_done <= 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_edge_from  = r_from;
    assign o_edge_to    = r_to;
    assign o_chosen_lag = r_lag_out;
    assign o_edge_valid = r_edge_valid;
    assign o_overflow   = r_ovf;
    assign o_last_edge  = r_last;

    `OPLS_ASSERT_IMP(a_edge_span, i_clk, i_rst_n, r_valid && r_edge_valid, r_to == r_from + ADDR_W'(r_lag_out), "edge end is not start plus lag")
    `OPLS_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, r_valid && r_last, !r_valid && r_state == S_IDLE, "word after final edge")
    `OPLS_ASSERT_IMP(a_short_single, i_clk, i_rst_n, r_valid && !r_edge_valid, r_last && r_lag_out == '0, "invalid word not final")
    `OPLS_ASSERT_IMP(a_done_in_drain, i_clk, i_rst_n, r_search_done, r_state == S_DRAIN, "search finished outside drain")
endmodule

@@ bench/orbit_period_lag_search_core_test.sv @@
// Testbench for orbit_period_lag_search_core: drives point sequences, predicts
// the chosen lag and emitted edges, and compares every result word.
// Depends on opls_pkg and the core RTL.
`timescale 1ns / 1ps

module orbit_period_lag_search_core_test;
    import opls_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] from_idx;
        logic [ADDR_W-1:0] to_idx;
        logic [LAG_W-1:0]  lag;
        logic              edge_ok;
        logic              ovf;
        logic              last;
    } t_edge;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_BITS-1:0] i_point_x;
    logic [COORD_BITS-1:0] i_point_y;
    logic                  i_last_point;
    logic                  o_valid;
    logic [ADDR_W-1:0]     o_edge_from;
    logic [ADDR_W-1:0]     o_edge_to;
    logic [LAG_W-1:0]      o_chosen_lag;
    logic                  o_edge_valid;
    logic                  o_overflow;
    logic                  o_last_edge;

    orbit_period_lag_search_core DUT (.*);

    logic signed [COORD_BITS-1:0] seq_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] seq_y [MAX_POINTS];
    int    seq_len;
    bit    seq_dropped;
    t_edge edge_queue[$];
    int    mismatches;
    bit    idle_on;
    longint cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("orbit_period_lag_search_core verification failed");
            $finish;
        end
    end

    function automatic void queue_edge(t_edge e);
        edge_queue.insert(edge_queue.size(), e);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned pair_dist(int a, int b);
        longint signed dx, dy;
        dx = longint'(seq_x[a]) - longint'(seq_x[b]);
        dy = longint'(seq_y[a]) - longint'(seq_y[b]);
        return isqrt(longint'(dx * dx + dy * dy));
    endfunction

    task automatic predict_edges();
        int half, best, n;
        longint unsigned sum, bsum, bcnt, cnt;
        t_edge e;
        n = seq_len;
        if (n < MIN_POINTS) begin
            e = '0;
            e.ovf = seq_dropped;
            e.last = 1'b1;
            queue_edge(e);
        end else begin
            half = n / 2;
            best = 0;
            bsum = 0;
            bcnt = 1;
            for (int lag = 1; lag < half; lag++) begin
                sum = 0;
                cnt = n - lag;
                for (int i = 0; i + lag < n; i++) sum += pair_dist(i, i + lag);
                if (best == 0 || sum * bcnt <= bsum * cnt) begin
                    best = lag;
                    bsum = sum;
                    bcnt = cnt;
                end
            end
            for (int i = 0; i < half; i++) begin
                e.from_idx = ADDR_W'(i);
                e.to_idx = ADDR_W'(i + best);
                e.lag = LAG_W'(best);
                e.edge_ok = 1'b1;
                e.ovf = seq_dropped;
                e.last = (i + 1 == half);
                queue_edge(e);
            end
        end
        seq_len = 0;
        seq_dropped = 0;
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, bit last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (busy);
        if (seq_len < MAX_POINTS) begin
            seq_x[seq_len] = x;
            seq_y[seq_len] = y;
            seq_len++;
        end else begin
            seq_dropped = 1;
        end
        if (last) predict_edges();
    endtask

    always @(posedge i_clk) begin
        t_edge got, want;
        if (i_rst_n && o_valid) begin
            got = {o_edge_from, o_edge_to, o_chosen_lag, o_edge_valid, o_overflow,
                   o_last_edge};
            if (edge_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = edge_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic run_sequence(int n, int mode);
        logic [15:0] x, y;
        int per;
        per = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin x = 16'($urandom); y = 16'($urandom); end
                1: begin
                    x = 16'((i % per) * 700 + $urandom_range(0, 40));
                    y = 16'(32'h8000 + (i % per) * 300 + $urandom_range(0, 40));
                end
                default: begin x = 16'h1234; y = 16'hEDCB; end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic test_short();
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b1);
        run_sequence(3, 0);
    endtask

    task automatic test_extremes();
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'hFFFF, 16'h0001, 1'b1);
        run_sequence(6, 2);
    endtask

    task automatic test_overflow();
        run_sequence(131, 1);
    endtask

    task automatic test_random();
        for (int k = 0; k < 12; k++) run_sequence($urandom_range(4, 14), k % 2);
    endtask

    task automatic test_quiet();
        idle_on = 0;
        for (int k = 0; k < 4; k++) run_sequence($urandom_range(1, 10), 1);
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        seq_len = 0;
        seq_dropped = 0;
        idle_on = 1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_last_point = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_short();
        test_extremes();
        test_overflow();
        test_random();
        test_quiet();
        start <= 1'b0;
        while (edge_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("orbit_period_lag_search_core verification clean");
        else
            $display("orbit_period_lag_search_core verification failed");
        $finish;
    end
endmodule
